### sv/rsame_pkg.sv
// Shared types and constants for the modular exponentiation block.
package rsame_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = $clog2(WORD_W);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam cnt_t CNT_LAST = CNT_W'(WORD_W - 1);

  // Register reset values
  localparam word_t EXP_RESET = WORD_W'(3);
  localparam word_t MOD_RESET = WORD_W'(10);

  // Register indexes (paddr[2])
  localparam logic REG_EXP = 1'b0;
  localparam logic REG_MOD = 1'b1;

  // Operand selection for one modular multiply
  typedef enum logic [1:0] {
    OP_RED,  // message * 1 mod m (initial reduction)
    OP_SQR,  // acc * acc mod m
    OP_MUL   // base * acc mod m
  } op_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // latch exponent, preset accumulator
    logic start;      // load multiplier operands, clear partial product
    op_e  op;
    logic step;       // one shift-add-reduce step
    logic fin_base;   // store the step result as reduced base
    logic fin_acc;    // store the step result as accumulator
    logic exp_shift;  // move to next exponent bit
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic exp_bit;    // current exponent bit, msb first
  } status_t;

endpackage

### sv/rsa_modular_exponentiation.sv
// Top level: register port, stream channels, controller and datapath.
//
// Usage: each request on the s_axis channel carries one 32-bit message word;
// the block returns message ^ exponent mod modulus as one request on the
// m_axis channel. Exponent (byte address 0) and modulus (byte address 4) are
// written over the APB-style port; reads return them. The user must write
// them only while the block is idle; the block does not enforce it. Reset
// sets exponent 3 and modulus 10 and empties the pipeline. The message is
// first reduced mod modulus, then each of the 32 exponent bits costs a
// squaring plus, when the bit is set, a multiply. Each modular multiply runs
// one bit of the multiplier per cycle through a single shift-add-reduce step.
// The block works on one item at a time; s_axis_tready is high only between
// items. The result sits in an output register; a stalled receiver holds it
// there and the controller waits with the finished result, so no new request
// is accepted until the register is free. Modulus 0 yields 0.
module rsa_modular_exponentiation (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] message
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] ciphertext
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rsame_pkg::word_t    exp_q, mod_q;
  rsame_pkg::word_t    out_data_q;
  logic                out_valid_q;
  rsame_pkg::word_t    result;
  rsame_pkg::cmd_t     cmd;
  rsame_pkg::status_t  status;
  logic                out_free;
  logic                res_push;
  logic                cfg_wr;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= rsame_pkg::EXP_RESET;
      mod_q <= rsame_pkg::MOD_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        rsame_pkg::REG_EXP: exp_q <= pwdata;
        rsame_pkg::REG_MOD: mod_q <= pwdata;
        default:            exp_q <= exp_q;
      endcase
    end
  end

  assign prdata = (paddr[2] == rsame_pkg::REG_MOD) ? mod_q : exp_q;

  // Output register
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  rsame_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .res_push_o (res_push),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rsame_dp u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .message_i  (s_axis_tdata),
    .exponent_i (exp_q),
    .modulus_i  (mod_q),
    .result_o   (result)
  );

endmodule

### sv/rsame_dp.sv
// Datapath: shift-add modular multiplier, operand and exponent registers.
module rsame_dp (
  input  logic                    clk_i,
  input  rsame_pkg::cmd_t         cmd_i,
  output rsame_pkg::status_t      status_o,
  input  rsame_pkg::word_t        message_i,
  input  rsame_pkg::word_t        exponent_i,
  input  rsame_pkg::word_t        modulus_i,
  output rsame_pkg::word_t        result_o
);

  localparam int unsigned W = rsame_pkg::WORD_W;

  rsame_pkg::word_t a_q, b_q, prod_q, acc_q, base_q, exp_q;
  rsame_pkg::word_t one_mod;
  rsame_pkg::word_t prod_d;
  logic [W+1:0]     sum;
  logic [W+1:0]     mod_x1, mod_x2;

  // 1 mod m
  assign one_mod = (modulus_i == W'(1)) ? '0 : W'(1);

  // One step: 2*p + bit*a, below 3m, then subtract 0, m or 2m
  always_comb begin
    mod_x1 = {2'b00, modulus_i};
    mod_x2 = {1'b0, modulus_i, 1'b0};
    sum    = {1'b0, prod_q, 1'b0} + (b_q[W-1] ? {2'b00, a_q} : '0);
    priority if (sum >= mod_x2) begin
      prod_d = W'(sum - mod_x2);
    end else if (sum >= mod_x1) begin
      prod_d = W'(sum - mod_x1);
    end else begin
      prod_d = W'(sum);
    end
  end

  // Operand and product registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      exp_q <= exponent_i;
      acc_q <= one_mod;
    end
    if (cmd_i.start) begin
      prod_q <= '0;
      unique case (cmd_i.op)
        rsame_pkg::OP_RED: begin
          a_q <= one_mod;
          b_q <= message_i;
        end
        rsame_pkg::OP_SQR: begin
          a_q <= acc_q;
          b_q <= acc_q;
        end
        rsame_pkg::OP_MUL: begin
          a_q <= base_q;
          b_q <= acc_q;
        end
        default: begin
          a_q <= acc_q;
          b_q <= acc_q;
        end
      endcase
    end else if (cmd_i.step) begin
      prod_q <= prod_d;
      b_q    <= {b_q[W-2:0], 1'b0};
    end
    if (cmd_i.fin_base) begin
      base_q <= prod_d;
    end
    if (cmd_i.fin_acc) begin
      acc_q <= prod_d;
    end
    if (cmd_i.exp_shift) begin
      exp_q <= {exp_q[W-2:0], 1'b0};
    end
  end

  assign status_o.exp_bit = exp_q[W-1];

  // Modulus zero gives zero
  assign result_o = (modulus_i == '0) ? '0 : acc_q;

endmodule

### sv/rsame_ctrl.sv
// Controller: sequences reduction, squarings and multiplies per exponent bit.
module rsame_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_free_i,
  output logic                res_push_o,
  input  rsame_pkg::status_t  status_i,
  output rsame_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_SQR_SET,
    S_SQR,
    S_MUL_SET,
    S_MUL,
    S_DONE
  } state_e;

  state_e          state_q;
  rsame_pkg::cnt_t step_q;
  rsame_pkg::cnt_t bit_q;
  logic            step_last;
  logic            bit_last;

  assign step_last = (step_q == rsame_pkg::CNT_LAST);
  assign bit_last  = (bit_q == rsame_pkg::CNT_LAST);

  // Command decode
  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = rsame_pkg::OP_RED;
    in_ready_o = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
        cmd_o.start = in_valid_i;
      end
      S_RED: begin
        cmd_o.step     = 1'b1;
        cmd_o.fin_base = step_last;
      end
      S_SQR_SET: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = rsame_pkg::OP_SQR;
      end
      S_SQR: begin
        cmd_o.step      = 1'b1;
        cmd_o.fin_acc   = step_last;
        cmd_o.exp_shift = step_last && !status_i.exp_bit;
      end
      S_MUL_SET: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = rsame_pkg::OP_MUL;
      end
      S_MUL: begin
        cmd_o.step      = 1'b1;
        cmd_o.fin_acc   = step_last;
        cmd_o.exp_shift = step_last;
      end
      S_DONE: begin
        res_push_o = out_free_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      bit_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          step_q <= '0;
          bit_q  <= '0;
          if (in_valid_i) begin
            state_q <= S_RED;
          end
        end
        S_RED: begin
          step_q <= step_q + 1'b1;
          if (step_last) begin
            state_q <= S_SQR_SET;
          end
        end
        S_SQR_SET: begin
          step_q  <= '0;
          state_q <= S_SQR;
        end
        S_SQR: begin
          step_q <= step_q + 1'b1;
          if (step_last) begin
            if (status_i.exp_bit) begin
              state_q <= S_MUL_SET;
            end else if (bit_last) begin
              state_q <= S_DONE;
            end else begin
              bit_q   <= bit_q + 1'b1;
              state_q <= S_SQR_SET;
            end
          end
        end
        S_MUL_SET: begin
          step_q  <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          step_q <= step_q + 1'b1;
          if (step_last) begin
            if (bit_last) begin
              state_q <= S_DONE;
            end else begin
              bit_q   <= bit_q + 1'b1;
              state_q <= S_SQR_SET;
            end
          end
        end
        S_DONE: begin
          if (out_free_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
